[rtl/page_table_walk_translate_core_defines.svh]
// Assertion macros for the page table walker.
// Simulation builds get the checks; synthesis builds see empty bodies.
`ifndef PAGE_TABLE_WALK_TRANSLATE_CORE_DEFINES_SVH
`define PAGE_TABLE_WALK_TRANSLATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PTWC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page table walker check failed");

// next-cycle implication
`define PTWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page table walker check failed");

`else

`define PTWC_ASSERT_NOW(label, clk, rst, ante, cons)

`define PTWC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/ptw_pkg.sv]
`timescale 1ns / 1ps

package ptw_pkg;

   localparam int LEVEL_INDEX_BITS = 9;
   localparam int LEVELS           = 4;
   localparam int OFFSET_BITS      = 12;
   localparam int ENTRY_BITS       = 64;
   localparam int FRAME_BITS       = 40;
   localparam int VA_BITS          = 48;
   localparam int PA_BITS          = 52;
   localparam int FUNC_BITS        = 2;
   localparam int WORD_INDEX_BITS  = 12;
   localparam int ENTRY_FRAME_LSB  = 12;
   localparam int ENTRY_FRAME_MSB  = 51;
   localparam int PRESENT_BIT      = 0;
   localparam int UPC_BITS         = 4;
   localparam int LVL_BITS         = 2;

   // table levels, top first
   localparam logic [LVL_BITS-1:0] LVL_TOP  = 2'd0;
   localparam logic [LVL_BITS-1:0] LVL_MID1 = 2'd1;
   localparam logic [LVL_BITS-1:0] LVL_MID2 = 2'd2;
   localparam logic [LVL_BITS-1:0] LVL_LEAF = 2'd3;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_XLAT  = 2'd1,
      FUNC_UNMAP = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ACT_NOP,
      ACT_CLEAR,
      ACT_ACCEPT,
      ACT_READ,
      ACT_LEAF,
      ACT_WRITE,
      ACT_ZERO
   } act_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_FUNC_WR,
      COND_FUNC_BAD,
      COND_ABSENT,
      COND_CLR_BUSY
   } cond_type;

   typedef logic [UPC_BITS-1:0] upc_type;

   localparam upc_type STEP_CLEAR     = 4'd0;
   localparam upc_type STEP_IDLE      = 4'd1;
   localparam upc_type STEP_DISPATCH  = 4'd2;
   localparam upc_type STEP_READ_TOP  = 4'd3;
   localparam upc_type STEP_READ_MID1 = 4'd4;
   localparam upc_type STEP_READ_MID2 = 4'd5;
   localparam upc_type STEP_READ_LEAF = 4'd6;
   localparam upc_type STEP_LEAF      = 4'd7;
   localparam upc_type STEP_WRITE     = 4'd8;
   localparam upc_type STEP_FAIL      = 4'd9;

   typedef struct packed {
      act_type             act;
      logic [LVL_BITS-1:0] lvl;
      logic                wait_rsp;
      cond_type            cond;
      upc_type             target;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic func_wr;
      logic func_bad;
      logic absent;
      logic clr_busy;
      logic rsp_free;
   } status_type;

   // Microprogram. Branch taken goes to target, otherwise to the next step.
   function automatic ucode_type ucode_rom(input upc_type upc);
      ucode_type w;
      case (upc)
         STEP_CLEAR: begin
            w = '{act: ACT_CLEAR, lvl: LVL_TOP, wait_rsp: 1'b0,
                  cond: COND_CLR_BUSY, target: STEP_CLEAR};
         end
         STEP_IDLE: begin
            w = '{act: ACT_ACCEPT, lvl: LVL_TOP, wait_rsp: 1'b0,
                  cond: COND_NO_REQ, target: STEP_IDLE};
         end
         STEP_DISPATCH: begin
            w = '{act: ACT_NOP, lvl: LVL_TOP, wait_rsp: 1'b0,
                  cond: COND_FUNC_WR, target: STEP_WRITE};
         end
         STEP_READ_TOP: begin
            w = '{act: ACT_READ, lvl: LVL_TOP, wait_rsp: 1'b0,
                  cond: COND_FUNC_BAD, target: STEP_FAIL};
         end
         STEP_READ_MID1: begin
            w = '{act: ACT_READ, lvl: LVL_MID1, wait_rsp: 1'b0,
                  cond: COND_ABSENT, target: STEP_FAIL};
         end
         STEP_READ_MID2: begin
            w = '{act: ACT_READ, lvl: LVL_MID2, wait_rsp: 1'b0,
                  cond: COND_ABSENT, target: STEP_FAIL};
         end
         STEP_READ_LEAF: begin
            w = '{act: ACT_READ, lvl: LVL_LEAF, wait_rsp: 1'b0,
                  cond: COND_ABSENT, target: STEP_FAIL};
         end
         STEP_LEAF: begin
            w = '{act: ACT_LEAF, lvl: LVL_TOP, wait_rsp: 1'b1,
                  cond: COND_ALWAYS, target: STEP_IDLE};
         end
         STEP_WRITE: begin
            w = '{act: ACT_WRITE, lvl: LVL_TOP, wait_rsp: 1'b1,
                  cond: COND_ALWAYS, target: STEP_IDLE};
         end
         STEP_FAIL: begin
            w = '{act: ACT_ZERO, lvl: LVL_TOP, wait_rsp: 1'b1,
                  cond: COND_ALWAYS, target: STEP_IDLE};
         end
         default: begin
            w = '{act: ACT_NOP, lvl: LVL_TOP, wait_rsp: 1'b0,
                  cond: COND_ALWAYS, target: STEP_IDLE};
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/page_table_walk_translate_core.sv]
// A translate/unmap result comes after the walk, early on a missing entry.
// One word is handled at a time, and the request side stalls until its response is loaded;
//   the walk is four dependent reads through the single table store read port.
// Reset: synchronous, active high; then a clearing sweep over every table word
//   zeroes the table store while req_stall stays high (csr writes taken throughout).
`timescale 1ns / 1ps
`include "page_table_walk_translate_core_defines.svh"

module page_table_walk_translate_core #(
   parameter int TABLE_WORDS = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request word
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ptw_pkg::FUNC_BITS-1:0]        req_func,
   input  logic [ptw_pkg::WORD_INDEX_BITS-1:0]  req_word_index,
   input  logic [ptw_pkg::ENTRY_BITS-1:0]       req_word_data,
   input  logic [ptw_pkg::VA_BITS-1:0]          req_virt_addr,
   // root frame register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptw_pkg::FRAME_BITS-1:0]       csr_root_frame,
   // response word
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ptw_pkg::PA_BITS-1:0]          rsp_phys_addr,
   output logic                                 rsp_found,
   output logic                                 rsp_invalidate
);
   import ptw_pkg::*;

   // TABLE_WORDS must be a power of two; frames then wrap into the store
   // by simply dropping the upper bits of frame*512 + index.
   localparam int ADDR_BITS = $clog2(TABLE_WORDS);

   ucode_type              ctl;
   status_type             status;

   logic                   mem_wr_en;
   logic [ADDR_BITS-1:0]   mem_wr_addr;
   logic [ENTRY_BITS-1:0]  mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_BITS-1:0]   mem_rd_addr;
   logic [ENTRY_BITS-1:0]  mem_rd_data;

   // Microcode sequencer: step counter plus ROM. Program outline:
   //   clear sweep -> idle (take a word) -> dispatch on func
   //   write:     one store write, zero response
   //   walk:      top, mid1, mid2, leaf reads; each read after the first
   //              checks the present bit of the word just read and bails
   //              to the fail step when it is clear
   //   leaf:      translate checks the leaf and answers the address;
   //              unmap zeroes the leaf slot and flags invalidate
   //   fail:      zero response (also used for the unused func code)
   // Response steps hold while the output register is still occupied.
   ptw_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   // Datapath: item latch, walk address generation, clear counter,
   // root frame register and the response register.
   ptw_dpath #(
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .status         (status),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .req_virt_addr  (req_virt_addr),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_root_frame (csr_root_frame),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_phys_addr  (rsp_phys_addr),
      .rsp_found      (rsp_found),
      .rsp_invalidate (rsp_invalidate),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // Table store: one write port, one registered read port.
   ptw_store #(
      .ADDR_BITS (ADDR_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // no request is taken while the store is being swept
   `PTWC_ASSERT_NOW(a_stall_in_clear, clock, reset, ctl.act == ACT_CLEAR, req_stall)
   // a taken word closes the request side on the next cycle
   `PTWC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   // invalidate only comes with a cleared leaf and a zero address
   `PTWC_ASSERT_NOW(a_inval_shape, clock, reset, rsp_valid && rsp_invalidate, rsp_found && (rsp_phys_addr == '0))
   // walk reads never share a cycle with a store write
   `PTWC_ASSERT_NOW(a_no_rw_clash, clock, reset, mem_wr_en, !mem_rd_en)

endmodule

[rtl/ptw_store.sv]
`timescale 1ns / 1ps

module ptw_store #(
   parameter int ADDR_BITS = 12
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADDR_BITS-1:0]              wr_addr,
   input  logic [ptw_pkg::ENTRY_BITS-1:0]    wr_data,
   input  logic                              rd_en,
   input  logic [ADDR_BITS-1:0]              rd_addr,
   output logic [ptw_pkg::ENTRY_BITS-1:0]    rd_data
);
   import ptw_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [ENTRY_BITS-1:0] mem [DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read word holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ptw_seq.sv]
`timescale 1ns / 1ps

module ptw_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  ptw_pkg::status_type    status,
   output ptw_pkg::ucode_type     ctl
);
   import ptw_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;
   logic    branch;
   logic    hold;

   assign ctl  = ucode_rom(upc_ff);
   assign hold = ctl.wait_rsp && !status.rsp_free;

   always_comb begin
      case (ctl.cond)
         COND_NEXT:     branch = 1'b0;
         COND_ALWAYS:   branch = 1'b1;
         COND_NO_REQ:   branch = status.no_req;
         COND_FUNC_WR:  branch = status.func_wr;
         COND_FUNC_BAD: branch = status.func_bad;
         COND_ABSENT:   branch = status.absent;
         COND_CLR_BUSY: branch = status.clr_busy;
         default:       branch = 1'b0;
      endcase
   end

   always_comb begin
      if (hold) begin
         upc_in = upc_ff;
      end else if (branch) begin
         upc_in = ctl.target;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

[rtl/ptw_dpath.sv]
`timescale 1ns / 1ps

module ptw_dpath #(
   parameter int ADDR_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptw_pkg::ucode_type                   ctl,
   output ptw_pkg::status_type                  status,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ptw_pkg::FUNC_BITS-1:0]        req_func,
   input  logic [ptw_pkg::WORD_INDEX_BITS-1:0]  req_word_index,
   input  logic [ptw_pkg::ENTRY_BITS-1:0]       req_word_data,
   input  logic [ptw_pkg::VA_BITS-1:0]          req_virt_addr,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptw_pkg::FRAME_BITS-1:0]       csr_root_frame,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ptw_pkg::PA_BITS-1:0]          rsp_phys_addr,
   output logic                                 rsp_found,
   output logic                                 rsp_invalidate,
   output logic                                 mem_wr_en,
   output logic [ADDR_BITS-1:0]                 mem_wr_addr,
   output logic [ptw_pkg::ENTRY_BITS-1:0]       mem_wr_data,
   output logic                                 mem_rd_en,
   output logic [ADDR_BITS-1:0]                 mem_rd_addr,
   input  logic [ptw_pkg::ENTRY_BITS-1:0]       mem_rd_data
);
   import ptw_pkg::*;

   localparam int WIDX_EXT = (ADDR_BITS > WORD_INDEX_BITS) ? ADDR_BITS : WORD_INDEX_BITS;

   // latched item
   logic [FUNC_BITS-1:0]       func_ff;
   logic [WORD_INDEX_BITS-1:0] windex_ff;
   logic [ENTRY_BITS-1:0]      wdata_ff;
   logic [VA_BITS-1:0]         va_ff;

   logic [FRAME_BITS-1:0]      root_frame_ff;
   logic [ADDR_BITS-1:0]       clr_cnt_ff;
   logic [ADDR_BITS-1:0]       slot_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [PA_BITS-1:0]         rsp_phys_ff;
   logic [PA_BITS-1:0]         rsp_phys_in;
   logic                       rsp_found_ff;
   logic                       rsp_found_in;
   logic                       rsp_inval_ff;
   logic                       rsp_inval_in;

   logic                       accept;
   logic                       rsp_free;
   logic                       act_en;
   logic                       rsp_load;
   logic                       present;
   logic [FRAME_BITS-1:0]      walk_frame;
   logic [LEVEL_INDEX_BITS-1:0] walk_idx;
   logic [FRAME_BITS+LEVEL_INDEX_BITS-1:0] slot_wide;
   logic [WIDX_EXT-1:0]        widx_ext;

   assign req_stall = (ctl.act != ACT_ACCEPT);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign act_en    = !(ctl.wait_rsp && !rsp_free);
   assign rsp_load  = ctl.wait_rsp && rsp_free;
   assign present   = mem_rd_data[PRESENT_BIT];

   assign status.no_req   = !req_valid;
   assign status.func_wr  = (func_ff == FUNC_WRITE);
   assign status.func_bad = !(func_ff inside {FUNC_XLAT, FUNC_UNMAP});
   assign status.absent   = !present;
   assign status.clr_busy = (clr_cnt_ff != {ADDR_BITS{1'b1}});
   assign status.rsp_free = rsp_free;

   // top level walks from the root, lower levels from the word just read
   assign walk_frame = (ctl.lvl == LVL_TOP) ? root_frame_ff
                                            : mem_rd_data[ENTRY_FRAME_MSB:ENTRY_FRAME_LSB];

   always_comb begin
      case (ctl.lvl)
         LVL_TOP:  walk_idx = va_ff[OFFSET_BITS + 3*LEVEL_INDEX_BITS +: LEVEL_INDEX_BITS];
         LVL_MID1: walk_idx = va_ff[OFFSET_BITS + 2*LEVEL_INDEX_BITS +: LEVEL_INDEX_BITS];
         LVL_MID2: walk_idx = va_ff[OFFSET_BITS + LEVEL_INDEX_BITS +: LEVEL_INDEX_BITS];
         default:  walk_idx = va_ff[OFFSET_BITS +: LEVEL_INDEX_BITS];
      endcase
   end

   // frame * 512 + index, wrapped to the store size
   assign slot_wide   = {walk_frame, walk_idx};
   assign mem_rd_addr = slot_wide[ADDR_BITS-1:0];
   assign mem_rd_en   = (ctl.act == ACT_READ);

   assign widx_ext = WIDX_EXT'(windex_ff);

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_cnt_ff;
      mem_wr_data = '0;
      case (ctl.act)
         ACT_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ACT_WRITE: begin
            mem_wr_en   = act_en;
            mem_wr_addr = widx_ext[ADDR_BITS-1:0];
            mem_wr_data = wdata_ff;
         end
         ACT_LEAF: begin
            mem_wr_en   = act_en && (func_ff == FUNC_UNMAP);
            mem_wr_addr = slot_ff;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_phys_in  = '0;
      rsp_found_in = 1'b0;
      rsp_inval_in = 1'b0;
      if (ctl.act == ACT_LEAF) begin
         if (func_ff == FUNC_UNMAP) begin
            rsp_found_in = 1'b1;
            rsp_inval_in = 1'b1;
         end else if (present) begin
            // frame bits sit above a zero offset field, so the sum is a concat
            rsp_phys_in  = {mem_rd_data[ENTRY_FRAME_MSB:ENTRY_FRAME_LSB],
                            va_ff[OFFSET_BITS-1:0]};
            rsp_found_in = 1'b1;
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         windex_ff <= req_word_index;
         wdata_ff  <= req_word_data;
         va_ff     <= req_virt_addr;
      end
      if (mem_rd_en) begin
         slot_ff <= mem_rd_addr;
      end
      if (rsp_load) begin
         rsp_phys_ff  <= rsp_phys_in;
         rsp_found_ff <= rsp_found_in;
         rsp_inval_ff <= rsp_inval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            root_frame_ff <= csr_root_frame;
         end
         if (ctl.act == ACT_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phys_addr  = rsp_phys_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_invalidate = rsp_inval_ff;

endmodule
